FILE: hdl/complex_arith_unit_assert.svh
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared property templates for the complex arithmetic unit checks.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex_arith_unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex_arith_unit: next-cycle check failed");

`endif

FILE: hdl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, pipeline geometry and stage payload types.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 33;                   // quotient bits below 2^33
  localparam int NSTG      = 4 + DIV_STEPS + 3;    // total register stages
  localparam int MW        = 65 + FRAC_BITS;       // scaled dividend width
  localparam logic [65:0] HALF = 66'((67'(1) << FRAC_BITS) >> 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } s1_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic [63:0]        sq_r;
    logic [63:0]        sq_i;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
  } s2_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [64:0] raw_re;
    logic signed [64:0] raw_im;
    logic [63:0]        d;
  } s3_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] d;
    logic        neg_re;
    logic [64:0] mag_re;
    logic        neg_im;
    logic [64:0] mag_im;
  } s4_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [63:0] r;
    logic [32:0] mlow;
    logic [32:0] q;
  } lane_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        dz;
    logic [63:0] d;
    lane_t       re;
    lane_t       im;
  } dq_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [33:0] q;
  } rl_t;

  typedef struct packed {
    logic dz;
    rl_t  re;
    rl_t  im;
  } r1_t;

endpackage

FILE: hdl/complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of Q16.16 complex operands, saturated.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless out_ready holds the output;
// the 33-stage restoring divider sets the depth, one quotient bit per stage
// for both result parts.
// Each stage advances on its own, so bubbles collapse under output stalls.
// Reset (rst_n low, synchronous) empties all stages; payload is not cleared.
module complex_arith_unit import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_real,
  output logic signed [31:0] out_res_imag,
  output logic               out_saturated,
  output logic               out_div_zero
);

  localparam int ST_DQ = 4;
  localparam int ST_R1 = ST_DQ + DIV_STEPS + 1;
  localparam int ST_O  = ST_R1 + 1;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  dq_t  dq_r [0:DIV_STEPS];
  dq_t  dq_nxt;
  r1_t  r1_r, r1_nxt;
  cmd_t o_cmd_r;
  logic signed [31:0] o_re_r, o_im_r, o_re_nxt, o_im_nxt;
  logic o_sat_r, o_dz_r, o_sat_nxt;

  function automatic lane_t lane_prep(cmd_t c, logic neg, logic [64:0] mag,
                                      logic [63:0] d);
    lane_t       l;
    logic [MW-1:0] m;
    logic [65:0] v;
    l      = '0;
    l.neg  = neg;
    m      = MW'(mag) << FRAC_BITS;
    v      = (66'(mag) + HALF) >> FRAC_BITS;
    unique case (c)
      CMD_ADD, CMD_SUB: begin
        l.q = mag[32:0];
      end
      CMD_MUL: begin
        l.q   = v[32:0];
        l.ovf = |v[65:33];
      end
      CMD_DIV: begin
        l.r    = 64'(m[MW-1:33]);
        l.mlow = m[32:0];
        l.ovf  = (64'(m[MW-1:33]) >= d);
      end
      default: begin
        l.q = '0;
      end
    endcase
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [63:0] d);
    lane_t      o;
    logic [64:0] rr;
    logic        ge;
    o      = l;
    rr     = {l.r, l.mlow[32]};
    ge     = (rr >= {1'b0, d});
    o.r    = ge ? 64'(rr - {1'b0, d}) : rr[63:0];
    o.q    = {l.q[31:0], ge};
    o.mlow = {l.mlow[31:0], 1'b0};
    return o;
  endfunction

  function automatic dq_t div_advance(dq_t s);
    dq_t o;
    o = s;
    if (s.cmd == CMD_DIV) begin
      o.re = lane_step(s.re, s.d);
      o.im = lane_step(s.im, s.d);
    end
    return o;
  endfunction

  function automatic rl_t lane_round(lane_t l, cmd_t c, logic [63:0] d);
    rl_t o;
    o.neg = l.neg;
    o.ovf = l.ovf;
    o.q   = {1'b0, l.q};
    if (c == CMD_DIV && ({l.r, 1'b0} >= {1'b0, d})) begin
      o.q = 34'({1'b0, l.q} + 34'd1);
    end
    return o;
  endfunction

  function automatic logic [32:0] lane_clip(rl_t l);
    logic [33:0] limit;
    logic        clip;
    logic [31:0] m;
    limit = l.neg ? 34'h080000000 : 34'h07fffffff;
    clip  = l.ovf || (l.q > limit);
    m     = clip ? limit[31:0] : l.q[31:0];
    return {clip, (l.neg ? 32'(-m) : m)};
  endfunction

  // Stage i loads when empty or when the stage after it moves.
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Operand capture.
  always_comb begin
    s1_nxt.cmd = cmd_t'(in_cmd);
    s1_nxt.ar  = in_a_real;
    s1_nxt.ai  = in_a_imag;
    s1_nxt.br  = in_b_real;
    s1_nxt.bi  = in_b_imag;
  end

  // Products and add/subtract sums.
  always_comb begin
    s2_nxt.cmd  = s1_r.cmd;
    s2_nxt.p_rr = 64'(s1_r.ar) * 64'(s1_r.br);
    s2_nxt.p_ii = 64'(s1_r.ai) * 64'(s1_r.bi);
    s2_nxt.p_ri = 64'(s1_r.ar) * 64'(s1_r.bi);
    s2_nxt.p_ir = 64'(s1_r.ai) * 64'(s1_r.br);
    s2_nxt.sq_r = $unsigned(64'(s1_r.br) * 64'(s1_r.br));
    s2_nxt.sq_i = $unsigned(64'(s1_r.bi) * 64'(s1_r.bi));
    if (s1_r.cmd == CMD_SUB) begin
      s2_nxt.sum_re = 33'(s1_r.ar) - 33'(s1_r.br);
      s2_nxt.sum_im = 33'(s1_r.ai) - 33'(s1_r.bi);
    end else begin
      s2_nxt.sum_re = 33'(s1_r.ar) + 33'(s1_r.br);
      s2_nxt.sum_im = 33'(s1_r.ai) + 33'(s1_r.bi);
    end
  end

  // Combine products into numerators and the divisor.
  always_comb begin
    s3_nxt.cmd = s2_r.cmd;
    s3_nxt.d   = s2_r.sq_r + s2_r.sq_i;
    unique case (s2_r.cmd)
      CMD_MUL: begin
        s3_nxt.raw_re = 65'(s2_r.p_rr) - 65'(s2_r.p_ii);
        s3_nxt.raw_im = 65'(s2_r.p_ri) + 65'(s2_r.p_ir);
      end
      CMD_DIV: begin
        s3_nxt.raw_re = 65'(s2_r.p_rr) + 65'(s2_r.p_ii);
        s3_nxt.raw_im = 65'(s2_r.p_ir) - 65'(s2_r.p_ri);
      end
      default: begin
        s3_nxt.raw_re = 65'(s2_r.sum_re);
        s3_nxt.raw_im = 65'(s2_r.sum_im);
      end
    endcase
  end

  // Split into sign and magnitude.
  always_comb begin
    s4_nxt.cmd    = s3_r.cmd;
    s4_nxt.d      = s3_r.d;
    s4_nxt.neg_re = s3_r.raw_re[64];
    s4_nxt.neg_im = s3_r.raw_im[64];
    s4_nxt.mag_re = s3_r.raw_re[64] ? 65'(-s3_r.raw_re) : s3_r.raw_re;
    s4_nxt.mag_im = s3_r.raw_im[64] ? 65'(-s3_r.raw_im) : s3_r.raw_im;
  end

  // Pass add/subtract magnitudes, scale and round the product, or seed the divider.
  always_comb begin
    dq_nxt.cmd = s4_r.cmd;
    dq_nxt.d   = s4_r.d;
    dq_nxt.dz  = (s4_r.cmd == CMD_DIV) && (s4_r.d == '0);
    dq_nxt.re  = lane_prep(s4_r.cmd, s4_r.neg_re, s4_r.mag_re, s4_r.d);
    dq_nxt.im  = lane_prep(s4_r.cmd, s4_r.neg_im, s4_r.mag_im, s4_r.d);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
    if (en[3]) begin
      s4_r <= s4_nxt;
    end
    if (en[ST_DQ]) begin
      dq_r[0] <= dq_nxt;
    end
    // One restoring quotient bit per stage; other opcodes pass through.
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (en[ST_DQ + k]) begin
        dq_r[k] <= div_advance(dq_r[k-1]);
      end
    end
  end

  always_comb begin
    r1_nxt.dz = dq_r[DIV_STEPS].dz;
    r1_nxt.re = lane_round(dq_r[DIV_STEPS].re, dq_r[DIV_STEPS].cmd, dq_r[DIV_STEPS].d);
    r1_nxt.im = lane_round(dq_r[DIV_STEPS].im, dq_r[DIV_STEPS].cmd, dq_r[DIV_STEPS].d);
  end

  // Clip, negate, and zero on divide by zero.
  always_comb begin
    logic [32:0] cr;
    logic [32:0] ci;
    cr = lane_clip(r1_r.re);
    ci = lane_clip(r1_r.im);
    if (r1_r.dz) begin
      o_re_nxt  = '0;
      o_im_nxt  = '0;
      o_sat_nxt = 1'b0;
    end else begin
      o_re_nxt  = cr[31:0];
      o_im_nxt  = ci[31:0];
      o_sat_nxt = cr[32] || ci[32];
    end
  end

  cmd_t r1_cmd_r;

  always_ff @(posedge clk) begin
    if (en[ST_R1]) begin
      r1_r     <= r1_nxt;
      r1_cmd_r <= dq_r[DIV_STEPS].cmd;
    end
    if (en[ST_O]) begin
      o_re_r  <= o_re_nxt;
      o_im_r  <= o_im_nxt;
      o_sat_r <= o_sat_nxt;
      o_dz_r  <= r1_r.dz;
      o_cmd_r <= r1_cmd_r;
    end
  end

  assign out_valid     = v_r[NSTG-1];
  assign out_res_real  = o_re_r;
  assign out_res_imag  = o_im_r;
  assign out_saturated = o_sat_r;
  assign out_div_zero  = o_dz_r;

  `include "complex_arith_unit_assert.svh"

  `CAU_ASSERT_NOW(a_dz_zero, out_valid && out_div_zero, (out_res_real == 0) && (out_res_imag == 0) && !out_saturated)
  `CAU_ASSERT_NOW(a_dz_cmd, out_valid && out_div_zero, o_cmd_r == CMD_DIV)
  `CAU_ASSERT_NEXT(a_fill, in_valid && in_ready, v_r[0])

endmodule

FILE: tb/tb_complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives add, subtract, multiply and divide transactions with random idle
// bursts on both channels and checks every result against a bit-exact
// fixed-point predictor of the unit.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit import cau_pkg::*;;

  localparam int NUM_RANDOM = 930;
  localparam int QUIET_FROM = 780;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               sat;
    logic               dz;
  } cplx_res_t;

  class cplx_scoreboard;
    cplx_res_t pending[$];
    int        errors = 0;

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Magnitude clipped to the signed 32-bit range, flagging saturation.
    function logic [31:0] clip(logic neg, logic [127:0] mag, inout logic sat);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (mag > lim) begin
        sat = 1'b1;
        mag = lim;
      end
      return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function logic [31:0] from_signed(logic signed [127:0] v, inout logic sat);
      logic [127:0] mag;
      mag = v < 0 ? -v : v;
      return clip(v < 0, mag, sat);
    endfunction

    function logic [31:0] scale_prod(logic signed [127:0] p, inout logic sat);
      logic [127:0] mag;
      mag = p < 0 ? -p : p;
      mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return clip(p < 0, mag, sat);
    endfunction

    function logic [31:0] quotient(logic signed [127:0] num, logic [127:0] d,
                                   inout logic sat);
      logic [127:0] mag, qv, rem;
      mag = num < 0 ? -num : num;
      mag = mag << FRAC_BITS;
      qv  = mag / d;
      rem = mag % d;
      if (rem >= d - rem) qv = qv + 1;
      return clip(num < 0, qv, sat);
    endfunction

    function void note(cmd_t cmd, logic signed [31:0] ar, logic signed [31:0] ai,
                       logic signed [31:0] br, logic signed [31:0] bi);
      cplx_res_t         e;
      logic signed [127:0] xr, xi, xbr, xbi, t1, t2, num_re, num_im;
      logic [127:0]      d;
      e = '0;
      xr = ar; xi = ai; xbr = br; xbi = bi;
      case (cmd)
        CMD_ADD: begin
          e.re = from_signed(xr + xbr, e.sat);
          e.im = from_signed(xi + xbi, e.sat);
        end
        CMD_SUB: begin
          e.re = from_signed(xr - xbr, e.sat);
          e.im = from_signed(xi - xbi, e.sat);
        end
        CMD_MUL: begin
          t1 = xr * xbr; t2 = xi * xbi;
          e.re = scale_prod(t1 - t2, e.sat);
          t1 = xr * xbi; t2 = xi * xbr;
          e.im = scale_prod(t1 + t2, e.sat);
        end
        default: begin
          d = xbr * xbr + xbi * xbi;
          if (d == 0) begin
            e.dz = 1'b1;
          end else begin
            t1 = xr * xbr; t2 = xi * xbi;
            num_re = t1 + t2;
            t1 = xi * xbr; t2 = xr * xbi;
            num_im = t1 - t2;
            e.re = quotient(num_re, d, e.sat);
            e.im = quotient(num_im, d, e.sat);
          end
        end
      endcase
      pending.push_back(e);
    endfunction

    task check(cplx_res_t got);
      cplx_res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result re=%h im=%h", got.re, got.im));
        return;
      end
      e = pending.pop_front();
      if (got.re !== e.re)
        report($sformatf("res_real got %h exp %h", got.re, e.re));
      if (got.im !== e.im)
        report($sformatf("res_imag got %h exp %h", got.im, e.im));
      if (got.sat !== e.sat)
        report($sformatf("saturated got %b exp %b", got.sat, e.sat));
      if (got.dz !== e.dz)
        report($sformatf("div_zero got %b exp %b", got.dz, e.dz));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = '0;
  logic signed [31:0] in_a_real = '0;
  logic signed [31:0] in_a_imag = '0;
  logic signed [31:0] in_b_real = '0;
  logic signed [31:0] in_b_imag = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_res_real;
  logic signed [31:0] out_res_imag;
  logic               out_saturated;
  logic               out_div_zero;

  cplx_scoreboard sb = new();
  int  sent = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;

  complex_arith_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels and the stall watchdog at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note(cmd_t'(in_cmd), in_a_real, in_a_imag, in_b_real, in_b_imag);
      if (out_valid && out_ready)
        sb.check('{out_res_real, out_res_imag, out_saturated, out_div_zero});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Send one transaction, preceded by an optional idle burst.
  task automatic send(cmd_t cmd, logic [31:0] ar, logic [31:0] ai,
                      logic [31:0] br, logic [31:0] bi);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd    <= cmd;
    in_a_real <= ar;
    in_a_imag <= ai;
    in_b_real <= br;
    in_b_imag <= bi;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      1: case ($urandom_range(0, 5))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           3: return 32'h0001_0000;
           4: return 32'hffff_ffff;
           default: return 32'h1;
         endcase
      2: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      default: return $urandom();
    endcase
  endfunction

  // Hold off ready in random bursts until the quiet phase.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cmd_t c;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes, every opcode, divide by zero, saturation and rounding ties.
    send(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff);
    send(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(CMD_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0);
    send(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff);
    send(CMD_SUB, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0);
    send(CMD_SUB, 32'h0, 32'h0, 32'h0, 32'h0);
    send(CMD_MUL, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0002_0000);
    send(CMD_MUL, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000);
    send(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(CMD_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send(CMD_MUL, 32'h1, 32'h0, 32'h0000_8000, 32'h0);
    send(CMD_MUL, 32'hffff_ffff, 32'h0, 32'h0000_8000, 32'h0);
    send(CMD_MUL, 32'h3, 32'h1, 32'h0000_8000, 32'h0000_8000);
    send(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send(CMD_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    send(CMD_DIV, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0);
    send(CMD_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h0);
    send(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h1);
    send(CMD_DIV, 32'h1, 32'h0, 32'h0002_0000, 32'h0);
    send(CMD_DIV, 32'hffff_ffff, 32'h0, 32'h0002_0000, 32'h0);
    send(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(CMD_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);

    repeat (NUM_RANDOM) begin
      c = cmd_t'($urandom_range(0, 3));
      if (c == CMD_DIV && $urandom_range(0, 19) == 0)
        send(c, pick_val(), pick_val(), 32'h0, 32'h0);
      else
        send(c, pick_val(), pick_val(), pick_val(), pick_val());
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/cau_pkg.sv
hdl/complex_arith_unit.sv
tb/tb_complex_arith_unit.sv
